/* hdl/dbt_pkg.sv */
// Shared types and constants of the dirty block tracker.
package dbt_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int NUM_RANGES_DEF = 8;

    localparam logic [12:0] BLOCK_BYTES_RESET   = 13'd256;
    localparam logic [6:0]  BLOCKS_IN_USE_RESET = 7'd64;
    localparam logic [12:0] BYTES_MAX           = 13'd4096;

    localparam logic REG_BLOCK_BYTES   = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    localparam logic FUNC_MARK = 1'b0;
    localparam logic FUNC_XFER = 1'b1;

    localparam logic [1:0] KIND_MARK_DONE = 2'd0;
    localparam logic [1:0] KIND_COPY      = 2'd1;
    localparam logic [1:0] KIND_NONE      = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  block_number;
        logic [17:0] source_offset;
        logic [20:0] dest_offset;
        logic        clamped;
        logic        last;
    } dbt_result_t;

    typedef struct packed {
        logic        func;
        logic [2:0]  range_number;
        logic [17:0] byte_offset;
        logic [18:0] byte_count;
    } dbt_item_t;

endpackage

/* hdl/dbt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/dbt_seq.sv */
// Sequencer that walks the dirty mask table for mark and transfer items.
module dbt_seq #(
    parameter int MAX_BLOCKS = dbt_pkg::MAX_BLOCKS_DEF,
    parameter int NUM_RANGES = dbt_pkg::NUM_RANGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dbt_pkg::dbt_item_t  in_item,
    input  logic [12:0]         block_bytes,
    input  logic [6:0]          blocks_in_use,
    input  logic                out_free,
    output logic                out_push,
    output dbt_pkg::dbt_result_t out_item
);

    import dbt_pkg::*;

    localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BLK_CW = $clog2(MAX_BLOCKS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP1 = 3'd1;
    localparam logic [2:0] S_PREP2 = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_EV    = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic                   func_reg;
    logic [2:0]             rng_reg;
    logic [18:0]            off_reg;
    logic                   cnt_nz_reg;
    logic [18:0]            lastbyte_reg;
    logic [12:0]            bb_reg;
    logic [BLK_CW-1:0]      nb_reg;
    logic [18:0]            total_reg;
    logic [20:0]            base_reg;
    logic [BLK_CW-1:0]      idx_reg;
    logic [18:0]            start_reg;
    logic [MAX_BLOCKS-1:0]  vld_reg;
    logic                   vld_q_reg;
    logic                   pend_vld_reg;
    dbt_result_t            pend_reg;

    logic [12:0]            bb_eff;
    logic [BLK_CW-1:0]      nb_eff;
    logic                   rng_ok;
    logic [NUM_RANGES-1:0]  bitmask;
    logic [NUM_RANGES-1:0]  rdata;
    logic [NUM_RANGES-1:0]  cur_mask;
    logic                   ram_we;
    logic [NUM_RANGES-1:0]  ram_wdata;
    logic                   ram_re;
    logic                   covered;
    logic                   hit;
    logic                   advance;
    logic                   at_end;
    logic [18:0]            start_end;
    dbt_result_t            new_cmd;

    always_comb
    begin
        if (block_bytes == 13'd0)
        begin
            bb_eff = 13'd1;
        end
        else if (block_bytes > BYTES_MAX)
        begin
            bb_eff = BYTES_MAX;
        end
        else
        begin
            bb_eff = block_bytes;
        end
        if (blocks_in_use == 7'd0)
        begin
            nb_eff = BLK_CW'(1);
        end
        else if (blocks_in_use > 7'(MAX_BLOCKS))
        begin
            nb_eff = BLK_CW'(MAX_BLOCKS);
        end
        else
        begin
            nb_eff = BLK_CW'(blocks_in_use);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_RANGES; k++)
        begin
            bitmask[k] = (rng_reg == 3'(k));
        end
    end

    assign rng_ok    = {1'b0, rng_reg} < 4'(NUM_RANGES);
    assign cur_mask  = vld_q_reg ? rdata : {NUM_RANGES{1'b1}};
    assign start_end = start_reg + 19'(bb_reg);
    assign covered   = rng_ok && cnt_nz_reg && (start_reg <= lastbyte_reg)
                       && (start_end > off_reg);
    assign hit       = rng_ok && (|(cur_mask & bitmask));
    assign at_end    = (idx_reg + BLK_CW'(1)) == nb_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign ram_re    = (state_reg == S_RD);

    always_comb
    begin
        new_cmd               = '0;
        new_cmd.kind          = KIND_COPY;
        new_cmd.block_number  = 6'(idx_reg);
        new_cmd.source_offset = start_reg[17:0];
        new_cmd.dest_offset   = base_reg + {2'b00, start_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_wdata  = cur_mask;
        advance    = 1'b0;
        out_push   = 1'b0;
        out_item   = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP1;
                end
            end
            S_PREP1:
            begin
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                if (func_reg == FUNC_MARK)
                begin
                    ram_we    = covered;
                    ram_wdata = cur_mask | bitmask;
                    advance   = 1'b1;
                end
                else if (!hit)
                begin
                    advance = 1'b1;
                end
                else if (!pend_vld_reg || out_free)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = cur_mask & ~bitmask;
                    out_push  = pend_vld_reg;
                    advance   = 1'b1;
                end
                if (advance)
                begin
                    state_next = at_end ? S_DONE : S_RD;
                end
            end
            S_DONE:
            begin
                if (func_reg == FUNC_MARK)
                begin
                    out_item         = '0;
                    out_item.kind    = KIND_MARK_DONE;
                    out_item.clamped = rng_ok && cnt_nz_reg && (lastbyte_reg >= total_reg);
                    out_item.last    = 1'b1;
                end
                else if (pend_vld_reg)
                begin
                    out_item      = pend_reg;
                    out_item.last = 1'b1;
                end
                else
                begin
                    out_item      = '0;
                    out_item.kind = KIND_NONE;
                    out_item.last = 1'b1;
                end
                if (out_free)
                begin
                    out_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            vld_reg      <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                vld_reg[idx_reg[AW-1:0]] <= 1'b1;
            end
            if (state_reg == S_IDLE)
            begin
                pend_vld_reg <= 1'b0;
            end
            else if (state_reg == S_EV && func_reg == FUNC_XFER && hit && advance)
            begin
                pend_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg     <= in_item.func;
            rng_reg      <= in_item.range_number;
            off_reg      <= {1'b0, in_item.byte_offset};
            cnt_nz_reg   <= (in_item.byte_count != 19'd0);
            lastbyte_reg <= {1'b0, in_item.byte_offset} + in_item.byte_count - 19'd1;
            bb_reg       <= bb_eff;
            nb_reg       <= nb_eff;
        end
        if (state_reg == S_PREP1)
        begin
            total_reg <= 19'(nb_reg) * 19'(bb_reg);
            idx_reg   <= '0;
            start_reg <= '0;
        end
        if (state_reg == S_PREP2)
        begin
            base_reg <= 21'(rng_reg) * 21'(total_reg);
        end
        if (state_reg == S_RD)
        begin
            vld_q_reg <= vld_reg[idx_reg[AW-1:0]];
        end
        if (advance)
        begin
            idx_reg   <= idx_reg + BLK_CW'(1);
            start_reg <= start_end;
        end
        if (state_reg == S_EV && func_reg == FUNC_XFER && hit && advance)
        begin
            pend_reg <= new_cmd;
        end
    end

    dbt_ram #(
        .WIDTH (NUM_RANGES),
        .DEPTH (MAX_BLOCKS)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

endmodule

/* hdl/dirty_block_tracker_core.sv */
// Top level of the dirty block tracker: configuration, sequencer and output register.
//
// Input stream s_*: tuser carries func (0 mark, 1 transfer), tdata carries
// range_number, byte_offset and byte_count. Output stream m_*: tuser carries
// kind, tlast marks the final result of an item, tdata carries block_number,
// source_offset, dest_offset and clamped.
// Configuration: cfg_index 0 writes block_bytes, 1 writes blocks_in_use; always
// ready; they are to be written only while no item is in flight, which the block does not enforce.
// One item is taken at a time. Each item passes through setup (capture in S_IDLE,
// then S_PREP1 and S_PREP2), then per block in use a mask memory read (S_RD) and a
// modify and write back (S_EV), then S_DONE to issue its final result.
// A transfer gives one copy command per dirty block; a result is held back one
// step so that the last one can carry tlast. With no dirty block it gives one
// "nothing dirty" result.
// A single output register parts the two sides: s_tready returns as soon as the
// final result is loaded. When m_tready is low the walk halts at the next result
// it must issue and resumes when the register drains.
// Reset marks every range dirty in every block through per-entry valid bits, so
// no clearing pass is needed; registers return to 256 bytes and 64 blocks.
module dirty_block_tracker_core #(
    parameter int MAX_BLOCKS = dbt_pkg::MAX_BLOCKS_DEF,
    parameter int NUM_RANGES = dbt_pkg::NUM_RANGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // range_number[2:0], byte_offset[20:3], byte_count[39:21]
    input  logic [0:0]  s_tuser,    // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // block_number[5:0], source_offset[23:6],
                                    // dest_offset[44:24], clamped[45], zero[47:46]
    output logic [1:0]  m_tuser,    // kind[1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    import dbt_pkg::*;

    logic [12:0] block_bytes_reg;
    logic [6:0]  blocks_in_use_reg;
    logic        m_tvalid_reg;
    dbt_result_t m_item_reg;
    dbt_item_t   in_item;
    dbt_result_t out_item;
    logic        out_push;
    logic        out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg   <= BLOCK_BYTES_RESET;
            blocks_in_use_reg <= BLOCKS_IN_USE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BLOCK_BYTES:   block_bytes_reg   <= cfg_data;
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data[6:0];
                default:           block_bytes_reg   <= block_bytes_reg;
            endcase
        end
    end

    assign in_item.func         = s_tuser[0];
    assign in_item.range_number = s_tdata[2:0];
    assign in_item.byte_offset  = s_tdata[20:3];
    assign in_item.byte_count   = s_tdata[39:21];

    assign out_free = !m_tvalid_reg || m_tready;

    dbt_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .NUM_RANGES (NUM_RANGES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (in_item),
        .block_bytes   (block_bytes_reg),
        .blocks_in_use (blocks_in_use_reg),
        .out_free      (out_free),
        .out_push      (out_push),
        .out_item      (out_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= out_push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            m_item_reg <= out_item;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_item_reg.kind;
    assign m_tlast  = m_item_reg.last;
    assign m_tdata  = {2'b00, m_item_reg.clamped, m_item_reg.dest_offset,
                       m_item_reg.source_offset, m_item_reg.block_number};

endmodule
